/* hdl/rbbr_pkg.sv */
// Shared types and constants for the region bounding-box remapper.
// Holds the input and result item structs and the fixed field widths.
// No dependencies; the front end, back end and top level import this package.
package rbbr_pkg;

	// Fixed field widths
	localparam int IDX_W      = 24;
	localparam int PIX_W      = 25;
	localparam int LEN_W      = 13;
	localparam int OUT_XY_W   = 12;
	localparam int ORDER_W    = 6;
	localparam int DIV_STEPS  = 24;
	localparam int STEP_W     = 5;

	// Column length limits and reset value
	localparam logic [LEN_W-1:0] LEN_MAX   = 13'd4096;
	localparam logic [LEN_W-1:0] LEN_RESET = 13'd512;

	// One input item: a 1-based column-major pixel index and the end-of-region mark
	typedef struct packed {
		logic [PIX_W-1:0] pixel_index;
		logic             last_pixel;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [ORDER_W-1:0]  item_order;
		logic [IDX_W-1:0]    local_index;
		logic [OUT_XY_W-1:0] box_row_start;
		logic [OUT_XY_W-1:0] box_col_start;
		logic [LEN_W-1:0]    box_width;
		logic                overflow;
		logic                last_result;
	} out_item_t;

endpackage

/* hdl/rbbr_front.sv */
// Front end of the remapper: accepts pixel items and splits each index into
// row and column with a radix-2 restoring divider, one quotient bit a cycle.
// Depends on rbbr_pkg.
module rbbr_front
	import rbbr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  in_item_t                pixel,
	input  logic                    push,
	output logic                    full,
	input  logic [LEN_W-1:0]        eff_len,
	output logic                    ent_valid,
	input  logic                    ent_ready,
	output logic [2*COORD_BITS:0]   ent_data
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [LEN_W-1:0]    rem_q;
	logic [IDX_W-1:0]    dq_q;
	logic                last_q;

	logic                accept;
	logic [PIX_W-1:0]    idx_dec;
	logic [IDX_W-1:0]    p_zb;
	logic [LEN_W:0]      trial;
	logic [LEN_W:0]      diff;
	logic                ge;
	logic [LEN_W-1:0]    rem_nx;
	logic [COORD_BITS+LEN_W-1:0] rem_ext;
	logic [COORD_BITS+IDX_W-1:0] quo_ext;
	logic [COORD_BITS-1:0] row_sat;
	logic [COORD_BITS-1:0] col_sat;

	assign full   = busy_q;
	assign accept = push && !busy_q;

	// Convert to a 0-based index, treating zero as one and saturating above the range
	always_comb begin
		idx_dec = pixel.pixel_index - PIX_W'(1);
		if (pixel.pixel_index == '0) begin
			p_zb = '0;
		end else if (idx_dec[PIX_W-1]) begin
			p_zb = '1;
		end else begin
			p_zb = idx_dec[IDX_W-1:0];
		end
	end

	// One restoring division step: bring down the next dividend bit and trial-subtract
	always_comb begin
		trial  = {rem_q, dq_q[IDX_W-1]};
		diff   = trial - {1'b0, eff_len};
		ge     = (trial >= {1'b0, eff_len});
		rem_nx = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
	end

	// Divider sequencer; the quotient shifts into the dividend register from below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q && !done_q) begin
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end else if (done_q && ent_ready) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= '0;
			dq_q   <= p_zb;
			last_q <= pixel.last_pixel;
		end else if (busy_q && !done_q) begin
			rem_q <= rem_nx;
			dq_q  <= {dq_q[IDX_W-2:0], ge};
		end
	end

	// Saturate row and column to the coordinate range
	always_comb begin
		rem_ext = {{COORD_BITS{1'b0}}, rem_q};
		quo_ext = {{COORD_BITS{1'b0}}, dq_q};
		row_sat = (rem_ext[COORD_BITS+LEN_W-1:COORD_BITS] != '0) ? '1
			: rem_ext[COORD_BITS-1:0];
		col_sat = (quo_ext[COORD_BITS+IDX_W-1:COORD_BITS] != '0) ? '1
			: quo_ext[COORD_BITS-1:0];
	end

	assign ent_valid = done_q;
	assign ent_data  = {last_q, row_sat, col_sat};

endmodule

/* hdl/rbbr_fifo.sv */
// Two-entry queue that decouples the divider front end from the box back end.
// Self-contained; no package needed.
module rbbr_fifo #(
	parameter int WIDTH = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = ent_q[rptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wptr_q] <= wr_data;
		end
	end

endmodule

/* hdl/rbbr_back.sv */
// Back end of the remapper: keeps pixel coordinates and the running box, and on
// the last pixel widens the box and plays out every kept item with its local index.
// Depends on rbbr_pkg.
module rbbr_back
	import rbbr_pkg::*;
#(
	parameter int MAX_PIXELS = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [OUT_XY_W-1:0]   len_m1,
	input  logic                  q_empty,
	input  logic [2*COORD_BITS:0] q_data,
	output logic                  q_pop,
	output out_item_t             result,
	output logic                  empty,
	input  logic                  pop
);

	localparam int CB = COORD_BITS;
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int BW = (CB + 1 > LEN_W) ? CB + 1 : LEN_W;
	localparam int PW = BW + CB;
	localparam int SW = (PW + 1 > IDX_W) ? PW + 1 : IDX_W;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_BOX     = 3'd1;
	localparam logic [2:0] ST_READ    = 3'd2;
	localparam logic [2:0] ST_CALC    = 3'd3;
	localparam logic [2:0] ST_LOAD    = 3'd4;

	logic [2:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   k_q;
	logic [CB-1:0]   rmin_q;
	logic [CB-1:0]   rmax_q;
	logic [CB-1:0]   cmin_q;
	logic [CB-1:0]   cmax_q;
	logic            ovf_q;
	logic [BW-1:0]   rs_q;
	logic [BW-1:0]   cs_q;
	logic [BW-1:0]   width_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic [2*CB-1:0] mem_q [MAX_PIXELS];
	logic [2*CB-1:0] rd_s1;
	logic [BW-1:0]   lr_s2;
	logic [PW-1:0]   prod_s2;

	logic            q_last;
	logic [CB-1:0]   q_row;
	logic [CB-1:0]   q_col;
	logic            room;
	logic [BW-1:0]   rs_c;
	logic [BW-1:0]   cs_c;
	logic [BW-1:0]   rmax_p1;
	logic [BW-1:0]   lm1_x;
	logic [BW-1:0]   re_a;
	logic [BW-1:0]   re_c;
	logic [BW-1:0]   width_c;
	logic [BW-1:0]   rd_row;
	logic [BW-1:0]   rd_col;
	logic [BW-1:0]   lr_c;
	logic [BW-1:0]   lc_c;
	logic [SW-1:0]   sum_c;
	logic [AW+ORDER_W-1:0] k_ext;
	logic            is_last;
	logic            load;

	// Queue entry fields
	assign q_last = q_data[2*CB];
	assign q_row  = q_data[2*CB-1:CB];
	assign q_col  = q_data[CB-1:0];
	assign q_pop  = (state_q == ST_COLLECT) && !q_empty;
	assign room   = (count_q != CW'(MAX_PIXELS));

	// Widened box: clamp the top and left edges at zero, the bottom edge at the image
	always_comb begin
		rs_c    = (rmin_q == '0) ? '0 : BW'(rmin_q) - BW'(1);
		cs_c    = (cmin_q == '0) ? '0 : BW'(cmin_q) - BW'(1);
		rmax_p1 = BW'(rmax_q) + BW'(1);
		lm1_x   = BW'(len_m1);
		re_a    = (rmax_p1 > lm1_x) ? lm1_x : rmax_p1;
		re_c    = (re_a < rs_c) ? rs_c : re_a;
		width_c = re_c - rs_c + BW'(1);
	end

	// Local offsets of the item read from the store
	always_comb begin
		rd_row = BW'(rd_s1[2*CB-1:CB]);
		rd_col = BW'(rd_s1[CB-1:0]);
		lr_c   = (rd_row >= rs_q) ? rd_row - rs_q : '0;
		lc_c   = (rd_col >= cs_q) ? rd_col - cs_q : '0;
	end

	// Result assembly
	always_comb begin
		sum_c   = SW'(lr_s2) + SW'(prod_s2);
		k_ext   = {{ORDER_W{1'b0}}, k_q};
		is_last = ((CW+1)'(k_q) + (CW+1)'(1)) == (CW+1)'(count_q);
		load    = (state_q == ST_LOAD) && (!out_valid_q || pop);
	end

	// Region collection and play-out sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			k_q         <= '0;
			rmin_q      <= '1;
			rmax_q      <= '0;
			cmin_q      <= '1;
			cmax_q      <= '0;
			ovf_q       <= 1'b0;
			rs_q        <= '0;
			cs_q        <= '0;
			width_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (q_pop) begin
						if (room) begin
							count_q <= count_q + CW'(1);
							if (q_row < rmin_q) rmin_q <= q_row;
							if (q_row > rmax_q) rmax_q <= q_row;
							if (q_col < cmin_q) cmin_q <= q_col;
							if (q_col > cmax_q) cmax_q <= q_col;
						end else begin
							ovf_q <= 1'b1;
						end
						if (q_last) begin
							state_q <= ST_BOX;
						end
					end
				end
				ST_BOX: begin
					rs_q    <= rs_c;
					cs_q    <= cs_c;
					width_q <= width_c;
					k_q     <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load) begin
						if (is_last) begin
							count_q <= '0;
							rmin_q  <= '1;
							rmax_q  <= '0;
							cmin_q  <= '1;
							cmax_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Coordinate store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (q_pop && room) begin
			mem_q[count_q[AW-1:0]] <= {q_row, q_col};
		end
		if (state_q == ST_READ) begin
			rd_s1 <= mem_q[k_q];
		end
	end

	// Local index multiply and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			lr_s2   <= lr_c;
			prod_s2 <= width_q * lc_c[CB-1:0];
		end
		if (load) begin
			out_q.item_order    <= k_ext[ORDER_W-1:0];
			out_q.local_index   <= sum_c[IDX_W-1:0];
			out_q.box_row_start <= rs_q[OUT_XY_W-1:0];
			out_q.box_col_start <= cs_q[OUT_XY_W-1:0];
			out_q.box_width     <= width_q[LEN_W-1:0];
			out_q.overflow      <= ovf_q;
			out_q.last_result   <= is_last;
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	// The queue is left alone while a region plays out.
	a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> !q_pop)
		else $error("queue popped outside collection");

	// Handing over the final item clears the region.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (count_q == '0 && state_q == ST_COLLECT && !ovf_q))
		else $error("region not cleared after its final item");

	// Play-out never reads past the kept items.
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ((CW+1)'(k_q) < (CW+1)'(count_q)))
		else $error("store read beyond the kept items");

	// A pixel that finds the store full raises the overflow flag.
	a_overflow_set: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !room) |=> ovf_q)
		else $error("dropped item did not set overflow");

endmodule

/* hdl/region_bounding_box_remap_top.sv */
// Region bounding-box remapper, top level. The front end takes one input item at a time:
// after the accepting edge full stays high through the 24 divider steps and the hand-off.
// After a region's last pixel the results play out through the store read and the multiply;
// each is read from the store only once the one before is in the output register.
// Reset is asynchronous: control state clears, column_length returns to 512;
// the coordinate store is not cleared and needs no clearing pass.
module region_bounding_box_remap_top
	import rbbr_pkg::*;
#(
	parameter int MAX_PIXELS = 64,
	parameter int COORD_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             push,
	output logic             full,
	input  in_item_t         pixel,
	input  logic             pop,
	output logic             empty,
	output out_item_t        result
);

	logic [LEN_W-1:0]        col_len_q;
	logic [LEN_W-1:0]        eff_len;
	logic [LEN_W-1:0]        eff_len_m1;
	logic                    ent_valid;
	logic                    ent_ready;
	logic [2*COORD_BITS:0]   ent_data;
	logic                    fq_full;
	logic                    fq_empty;
	logic                    fq_pop;
	logic [2*COORD_BITS:0]   fq_data;

	// Column length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			col_len_q <= cfg_wdata;
		end
	end

	// Usable column length: zero reads as one, anything above the maximum as the maximum
	always_comb begin
		if (col_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (col_len_q > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = col_len_q;
		end
		eff_len_m1 = eff_len - LEN_W'(1);
	end

	assign ent_ready = !fq_full;

	rbbr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.push      (push),
		.full      (full),
		.eff_len   (eff_len),
		.ent_valid (ent_valid),
		.ent_ready (ent_ready),
		.ent_data  (ent_data)
	);

	rbbr_fifo #(
		.WIDTH (2*COORD_BITS + 1)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ent_valid),
		.wr_data (ent_data),
		.q_full  (fq_full),
		.rd_en   (fq_pop),
		.rd_data (fq_data),
		.q_empty (fq_empty)
	);

	rbbr_back #(
		.MAX_PIXELS (MAX_PIXELS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.len_m1  (eff_len_m1[OUT_XY_W-1:0]),
		.q_empty (fq_empty),
		.q_data  (fq_data),
		.q_pop   (fq_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
